@@ rtl/rbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbt_pkg: shared constants and types for the tagged reorder buffer
// Sizes, status codes, arithmetic unit operations and the RAM request bundle.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int TAG_W  = SLOT_W + 1;
  localparam int CNT_W  = TAG_W;
  localparam int ID_W   = 32;
  localparam int VAL_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STS_W  = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WB     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd3;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd1;
  localparam logic [STS_W-1:0] STS_NOT_READY = 3'd2;
  localparam logic [STS_W-1:0] STS_STALE     = 3'd3;
  localparam logic [STS_W-1:0] STS_BAD_FLUSH = 3'd4;

  // Shared arithmetic unit operations
  typedef logic [1:0] au_op_t;
  localparam au_op_t AU_PASS = 2'd0;
  localparam au_op_t AU_INC  = 2'd1;
  localparam au_op_t AU_DEC  = 2'd2;
  localparam au_op_t AU_SUB  = 2'd3;

  typedef struct packed {
    logic              val_we;
    logic [SLOT_W-1:0] val_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic              instr_we;
    logic [SLOT_W-1:0] instr_waddr;
    logic [ID_W-1:0]   instr_wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] val_rdata;
    logic [ID_W-1:0]  instr_rdata;
  } ram_rsp_t;

endpackage
`default_nettype wire

@@ rtl/reorder_buffer_tagged.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer_tagged: circular reorder buffer with phase-bit tags
// Allocate, writeback, flush-younger and retire commands on a DEPTH-entry
// buffer; one result beat per command beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in_*      input      in_valid/in_stall   command, instr_id, rob_tag, wb_value
//  out_*     output     out_valid/out_stall status, alloc_tag, retired_value,
//                                           retired_instr, next_head, occupancy
//
// One command beat at a time. Allocate and writeback pass decode and done; retire
// adds a state for the registered RAM read; flush ends after decode when empty,
// after check if none is dropped or the tag exceeds occupancy, else after the walk.
// rst_n is synchronous; it empties the buffer and clears the head and tail pointers.
// A result waiting under out_stall sits in the output register; one more beat
// is taken meanwhile and its result then waits for the register to drain.
// ----------------------------------------------------------------------------
module reorder_buffer_tagged (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [rbt_pkg::CMD_W-1:0]    in_command,
  input  wire logic [rbt_pkg::ID_W-1:0]     in_instr_id,
  input  wire logic [rbt_pkg::TAG_W-1:0]    in_rob_tag,
  input  wire logic [rbt_pkg::VAL_W-1:0]    in_wb_value,

  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [rbt_pkg::STS_W-1:0]    out_status,
  output      logic [rbt_pkg::TAG_W-1:0]    out_alloc_tag,
  output      logic [rbt_pkg::VAL_W-1:0]    out_retired_value,
  output      logic [rbt_pkg::ID_W-1:0]     out_retired_instr,
  output      logic [rbt_pkg::SLOT_W-1:0]   out_next_head,
  output      logic [rbt_pkg::CNT_W-1:0]    out_occupancy
);
  import rbt_pkg::*;

  ram_req_t ram_req;
  ram_rsp_t ram_rsp;

  rbt_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_instr_id       (in_instr_id),
    .in_rob_tag        (in_rob_tag),
    .in_wb_value       (in_wb_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_alloc_tag     (out_alloc_tag),
    .out_retired_value (out_retired_value),
    .out_retired_instr (out_retired_instr),
    .out_next_head     (out_next_head),
    .out_occupancy     (out_occupancy),
    .ram_req           (ram_req),
    .ram_rsp           (ram_rsp)
  );

  // Result values, written on writeback.
  rbt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_req.val_we),
    .waddr (ram_req.val_waddr),
    .wdata (ram_req.val_wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rsp.val_rdata)
  );

  // Instruction ids, written on allocate.
  rbt_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_instr_ram (
    .clk   (clk),
    .we    (ram_req.instr_we),
    .waddr (ram_req.instr_waddr),
    .wdata (ram_req.instr_wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rsp.instr_rdata)
  );

endmodule
`default_nettype wire

@@ rtl/rbt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/rbt_au.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbt_au: shared tag and count arithmetic unit
// Increment, decrement and subtract on tag-wide values, modulo 2*DEPTH.
// ----------------------------------------------------------------------------
module rbt_au (
  input  wire rbt_pkg::au_op_t            op,
  input  wire logic [rbt_pkg::TAG_W-1:0]  a,
  input  wire logic [rbt_pkg::TAG_W-1:0]  b,
  output      logic [rbt_pkg::TAG_W-1:0]  y
);
  import rbt_pkg::*;

  always_comb begin
    unique case (op)
      AU_INC:  y = a + TAG_W'(1);
      AU_DEC:  y = a - TAG_W'(1);
      AU_SUB:  y = a - b;
      default: y = a;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/rbt_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbt_seq: reorder buffer sequencer
// Holds the entry flags and pointers, steps flush commands through the shared
// arithmetic unit and drives the entry RAMs and the result register.
// ----------------------------------------------------------------------------
module rbt_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [rbt_pkg::CMD_W-1:0]    in_command,
  input  wire logic [rbt_pkg::ID_W-1:0]     in_instr_id,
  input  wire logic [rbt_pkg::TAG_W-1:0]    in_rob_tag,
  input  wire logic [rbt_pkg::VAL_W-1:0]    in_wb_value,

  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [rbt_pkg::STS_W-1:0]    out_status,
  output      logic [rbt_pkg::TAG_W-1:0]    out_alloc_tag,
  output      logic [rbt_pkg::VAL_W-1:0]    out_retired_value,
  output      logic [rbt_pkg::ID_W-1:0]     out_retired_instr,
  output      logic [rbt_pkg::SLOT_W-1:0]   out_next_head,
  output      logic [rbt_pkg::CNT_W-1:0]    out_occupancy,

  output      rbt_pkg::ram_req_t            ram_req,
  input  wire rbt_pkg::ram_rsp_t            ram_rsp
);
  import rbt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DEC    = 3'd1;
  localparam logic [2:0] ST_RET    = 3'd2;
  localparam logic [2:0] ST_FL_SUB = 3'd3;
  localparam logic [2:0] ST_FL_CHK = 3'd4;
  localparam logic [2:0] ST_WALK   = 3'd5;
  localparam logic [2:0] ST_FL_END = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [DEPTH-1:0]  ready_r, ready_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Latched command beat and working values
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [TAG_W-1:0]  tag_r;
  logic [VAL_W-1:0]  wv_r;
  logic [TAG_W-1:0]  new_tail_r, new_tail_nxt;
  logic [TAG_W-1:0]  removed_r, removed_nxt;
  logic [TAG_W-1:0]  walk_left_r, walk_left_nxt;
  logic [SLOT_W-1:0] walk_slot_r, walk_slot_nxt;

  // Result under construction
  logic [STS_W-1:0]  res_status_r, res_status_nxt;
  logic [TAG_W-1:0]  res_tag_r, res_tag_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;

  logic [STS_W-1:0]  out_status_r;
  logic [TAG_W-1:0]  out_alloc_tag_r;
  logic [VAL_W-1:0]  out_retired_value_r;
  logic [ID_W-1:0]   out_retired_instr_r;
  logic [SLOT_W-1:0] out_next_head_r;
  logic [CNT_W-1:0]  out_occupancy_r;

  au_op_t            au_op;
  logic [TAG_W-1:0]  au_a, au_b, au_y;
  logic              in_take;
  logic              out_load;
  logic [SLOT_W-1:0] wb_slot;

  rbt_au u_au (
    .op (au_op),
    .a  (au_a),
    .b  (au_b),
    .y  (au_y)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign wb_slot  = tag_r[SLOT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    ready_nxt      = ready_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    new_tail_nxt   = new_tail_r;
    removed_nxt    = removed_r;
    walk_left_nxt  = walk_left_r;
    walk_slot_nxt  = walk_slot_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_val_nxt    = res_val_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    au_op          = AU_PASS;
    au_a           = '0;
    au_b           = '0;

    ram_req             = '0;
    ram_req.val_waddr   = wb_slot;
    ram_req.val_wdata   = wv_r;
    ram_req.instr_waddr = tail_r;
    ram_req.instr_wdata = id_r;
    ram_req.raddr       = head_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          res_status_nxt = STS_OK;
          res_tag_nxt    = '0;
          res_val_nxt    = '0;
          res_id_nxt     = '0;
          state_nxt      = ST_DEC;
        end
      end

      ST_DEC: begin
        state_nxt = ST_DONE;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_status_nxt = STS_FULL;
            end else begin
              ram_req.instr_we = 1'b1;
              valid_nxt[tail_r] = 1'b1;
              ready_nxt[tail_r] = 1'b0;
              res_tag_nxt = {phase_r, tail_r};
              tail_nxt    = tail_r + SLOT_W'(1);
              if (tail_r == SLOT_W'(DEPTH - 1)) begin
                phase_nxt = ~phase_r;
              end
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_WB: begin
            if (!valid_r[wb_slot] || ready_r[wb_slot]) begin
              res_status_nxt = STS_STALE;
            end else begin
              ram_req.val_we     = 1'b1;
              ready_nxt[wb_slot] = 1'b1;
            end
          end
          CMD_FLUSH: begin
            if (count_r != '0) begin
              au_op        = AU_INC;
              au_a         = tag_r;
              new_tail_nxt = au_y;
              state_nxt    = ST_FL_SUB;
            end
          end
          default: begin
            // The head read is issued here; the data arrives in ST_RET.
            if (count_r == '0 || !valid_r[head_r] || !ready_r[head_r]) begin
              res_status_nxt = STS_NOT_READY;
            end else begin
              state_nxt = ST_RET;
            end
          end
        endcase
      end

      ST_RET: begin
        res_val_nxt       = ram_rsp.val_rdata;
        res_id_nxt        = ram_rsp.instr_rdata;
        valid_nxt[head_r] = 1'b0;
        ready_nxt[head_r] = 1'b0;
        head_nxt          = head_r + SLOT_W'(1);
        count_nxt         = count_r - CNT_W'(1);
        state_nxt         = ST_DONE;
      end

      ST_FL_SUB: begin
        au_op       = AU_SUB;
        au_a        = {phase_r, tail_r};
        au_b        = new_tail_r;
        removed_nxt = au_y;
        state_nxt   = ST_FL_CHK;
      end

      ST_FL_CHK: begin
        priority if (removed_r == '0) begin
          state_nxt = ST_DONE;
        end else if (removed_r > count_r) begin
          res_status_nxt = STS_BAD_FLUSH;
          state_nxt      = ST_DONE;
        end else begin
          walk_slot_nxt = new_tail_r[SLOT_W-1:0];
          walk_left_nxt = removed_r;
          state_nxt     = ST_WALK;
        end
      end

      ST_WALK: begin
        // One entry from the new tail upward is dropped each cycle.
        valid_nxt[walk_slot_r] = 1'b0;
        ready_nxt[walk_slot_r] = 1'b0;
        walk_slot_nxt          = walk_slot_r + SLOT_W'(1);
        au_op                  = AU_DEC;
        au_a                   = walk_left_r;
        walk_left_nxt          = au_y;
        if (walk_left_r == TAG_W'(1)) begin
          state_nxt = ST_FL_END;
        end
      end

      ST_FL_END: begin
        au_op     = AU_SUB;
        au_a      = count_r;
        au_b      = removed_r;
        count_nxt = au_y;
        tail_nxt  = new_tail_r[SLOT_W-1:0];
        phase_nxt = new_tail_r[TAG_W-1];
        state_nxt = ST_DONE;
      end

      default: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ready_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ready_r     <= ready_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_command;
      id_r  <= in_instr_id;
      tag_r <= in_rob_tag;
      wv_r  <= in_wb_value;
    end
    new_tail_r   <= new_tail_nxt;
    removed_r    <= removed_nxt;
    walk_left_r  <= walk_left_nxt;
    walk_slot_r  <= walk_slot_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_val_r    <= res_val_nxt;
    res_id_r     <= res_id_nxt;
    if (out_load) begin
      out_status_r        <= res_status_r;
      out_alloc_tag_r     <= res_tag_r;
      out_retired_value_r <= res_val_r;
      out_retired_instr_r <= res_id_r;
      out_next_head_r     <= head_r;
      out_occupancy_r     <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_tag     = out_alloc_tag_r;
  assign out_retired_value = out_retired_value_r;
  assign out_retired_instr = out_retired_instr_r;
  assign out_next_head     = out_next_head_r;
  assign out_occupancy     = out_occupancy_r;

endmodule
`default_nettype wire
